[design/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[design/mfq_pkg.sv]
`default_nettype none
package mfq_pkg;

    // Operation codes of an input item.
    typedef enum logic [1:0] {
        OP_ENQ  = 2'd0,
        OP_DISP = 2'd1,
        OP_AGE  = 2'd2,
        OP_NOP  = 2'd3
    } t_op;

    // Result status codes.
    localparam logic [2:0] STAT_ENQ  = 3'd0;
    localparam logic [2:0] STAT_DISP = 3'd1;
    localparam logic [2:0] STAT_NONE = 3'd2;
    localparam logic [2:0] STAT_FULL = 3'd3;
    localparam logic [2:0] STAT_AGED = 3'd4;

    // Level codes.
    localparam logic [1:0] LVL_NONE = 2'd0;
    localparam logic [1:0] LVL_1    = 2'd1;
    localparam logic [1:0] LVL_2    = 2'd2;
    localparam logic [1:0] LVL_3    = 2'd3;

    // Priority bands.
    localparam logic [7:0] PRI_L3_MAX = 8'd49;
    localparam logic [7:0] PRI_L2_MIN = 8'd50;
    localparam logic [7:0] PRI_L2_MAX = 8'd99;
    localparam logic [7:0] PRI_L1_MIN = 8'd100;
    localparam logic [7:0] PRI_L1_MAX = 8'd149;

    // Configuration register indexes and reset values.
    localparam logic [1:0] REG_THRESH = 2'd0;
    localparam logic [1:0] REG_BOOST  = 2'd1;
    localparam logic [1:0] REG_INC    = 2'd2;
    localparam logic [15:0] RST_THRESH = 16'd400;
    localparam logic [5:0]  RST_BOOST  = 6'd10;
    localparam logic [15:0] RST_INC    = 16'd100;

    typedef struct packed {
        logic [15:0] thresh;
        logic [5:0]  boost;
        logic [15:0] inc;
    } t_cfg;

    // Classified command passed from the front to the back.
    typedef struct packed {
        t_op         op;
        logic [15:0] thread;
        logic [7:0]  prio;
        logic [19:0] burst;
        logic [1:0]  level;
    } t_cmd;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] thread;
        logic [1:0]  level;
        logic [7:0]  prio;
    } t_res;

    typedef enum logic [1:0] {
        SM_IDLE,
        SM_SCAN,
        SM_DECIDE
    } t_state;

endpackage
`default_nettype wire

[design/mfq_front.sv]
`default_nettype none
module mfq_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire logic [1:0]    i_op,
    input  wire logic [15:0]   i_thread_id,
    input  wire logic [7:0]    i_priority_req,
    input  wire logic [19:0]   i_remaining_burst,
    output logic               o_cmd_valid,
    output mfq_pkg::t_cmd      o_cmd,
    input  wire logic          i_cmd_pop
);

    mfq_pkg::t_cmd r_q [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    mfq_pkg::t_cmd w_cmd;
    logic          w_push;

    // Classify the incoming item by its priority band.
    always_comb begin
        w_cmd.op     = mfq_pkg::t_op'(i_op);
        w_cmd.thread = i_thread_id;
        w_cmd.prio   = i_priority_req;
        w_cmd.burst  = i_remaining_burst;
        if (i_priority_req <= mfq_pkg::PRI_L3_MAX) begin
            w_cmd.level = mfq_pkg::LVL_3;
        end else if (i_priority_req <= mfq_pkg::PRI_L2_MAX) begin
            w_cmd.level = mfq_pkg::LVL_2;
        end else if (i_priority_req <= mfq_pkg::PRI_L1_MAX) begin
            w_cmd.level = mfq_pkg::LVL_1;
        end else begin
            w_cmd.level = mfq_pkg::LVL_NONE;
        end
    end

    assign o_in_ready  = (r_cnt != 2'd2);
    assign w_push      = i_in_valid && o_in_ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    // Two-entry queue between the front and the back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_cmd_pop};
        end
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

endmodule
`default_nettype wire

[design/mfq_back.sv]
`default_nettype none
module mfq_back #(
    parameter int MAX_THREADS = 16,
    localparam int IW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire mfq_pkg::t_cfg i_cfg,
    input  wire logic          i_cmd_valid,
    input  wire mfq_pkg::t_cmd i_cmd,
    output logic               o_cmd_pop,
    output logic               o_res_valid,
    input  wire logic          i_res_ready,
    output mfq_pkg::t_res      o_res
);

    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_THREADS - 1);

    // Slot table.
    logic             r_valid [MAX_THREADS];
    logic [15:0]      r_thr   [MAX_THREADS];
    logic [7:0]       r_pri   [MAX_THREADS];
    logic [16:0]      r_wait  [MAX_THREADS];
    logic [19:0]      r_burst [MAX_THREADS];
    logic [1:0]       r_lvl   [MAX_THREADS];
    logic [15:0]      r_arr   [MAX_THREADS];
    logic [MAX_THREADS-1:0] r_seen, n_seen;

    // Control and best-candidate registers.
    mfq_pkg::t_state  r_state, n_state;
    mfq_pkg::t_op     r_op, n_op;
    logic [1:0]       r_lv, n_lv;
    logic [IW-1:0]    r_idx, n_idx;
    logic [15:0]      r_base, n_base;
    logic [15:0]      r_cnt_arr, n_cnt_arr;
    logic             r_have, n_have;
    logic [IW-1:0]    r_b_idx, n_b_idx;
    logic [15:0]      r_b_thr, n_b_thr;
    logic [7:0]       r_b_pri, n_b_pri;
    logic [16:0]      r_b_wait, n_b_wait;
    logic [19:0]      r_b_burst, n_b_burst;
    logic [15:0]      r_b_arr, n_b_arr;
    logic             r_res_valid;
    mfq_pkg::t_res    r_res, n_res;
    logic             w_res_load;

    // Table write controls.
    logic             w_enq_wr, w_disp_clr, w_age_wr;
    logic [7:0]       w_age_pri;
    logic [16:0]      w_age_wait;
    logic [1:0]       w_age_lvl;
    logic [15:0]      w_age_arr;

    logic             w_out_free;
    logic             w_free_found;
    logic [IW-1:0]    w_free_idx;
    logic             w_cand, w_better, w_take;
    logic [15:0]      w_age_c, w_age_b;
    logic [16:0]      w_wsum;
    logic [8:0]       w_psum;
    logic [7:0]       w_psat;
    logic             w_fire;

    assign w_out_free  = !r_res_valid || i_res_ready;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // Lowest free slot for an enqueue.
    always_comb begin
        w_free_found = 1'b0;
        w_free_idx   = '0;
        for (int i = MAX_THREADS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                w_free_found = 1'b1;
                w_free_idx   = IW'(i);
            end
        end
    end

    // Compare the scanned slot against the best one found so far.
    always_comb begin
        w_cand  = r_valid[r_idx] && (r_lvl[r_idx] == r_lv) && !r_seen[r_idx];
        w_age_c = r_base - r_arr[r_idx];
        w_age_b = r_base - r_b_arr;
        if (r_lv == mfq_pkg::LVL_1 && r_burst[r_idx] != r_b_burst) begin
            w_better = r_burst[r_idx] < r_b_burst;
        end else if (r_lv == mfq_pkg::LVL_2 && r_thr[r_idx] != r_b_thr) begin
            w_better = r_thr[r_idx] < r_b_thr;
        end else begin
            w_better = w_age_c > w_age_b;
        end
        w_take = w_cand && (!r_have || w_better);
    end

    // Aging arithmetic on the chosen entry.
    always_comb begin
        w_wsum = r_b_wait + {1'b0, i_cfg.inc};
        w_psum = {1'b0, r_b_pri} + {3'b000, i_cfg.boost};
        w_psat = w_psum[8] ? 8'hFF : w_psum[7:0];
        w_fire = w_wsum > {1'b0, i_cfg.thresh};
        w_age_wait = w_fire ? 17'd0 : w_wsum;
        w_age_pri  = w_fire ? w_psat : r_b_pri;
        w_age_lvl  = r_lv;
        w_age_arr  = r_b_arr;
        if (w_fire && r_lv == mfq_pkg::LVL_3 && w_psat >= mfq_pkg::PRI_L2_MIN
                && w_psat <= mfq_pkg::PRI_L2_MAX) begin
            w_age_lvl = mfq_pkg::LVL_2;
            w_age_arr = r_cnt_arr;
        end else if (w_fire && r_lv == mfq_pkg::LVL_2 && w_psat >= mfq_pkg::PRI_L1_MIN) begin
            w_age_lvl = mfq_pkg::LVL_1;
            w_age_arr = r_cnt_arr;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            mfq_pkg::SM_IDLE: begin
                if (i_cmd_valid && w_out_free
                        && (i_cmd.op == mfq_pkg::OP_DISP || i_cmd.op == mfq_pkg::OP_AGE)) begin
                    n_state = mfq_pkg::SM_SCAN;
                end
            end
            mfq_pkg::SM_SCAN: begin
                if (r_idx == LAST_IDX) begin
                    n_state = mfq_pkg::SM_DECIDE;
                end
            end
            mfq_pkg::SM_DECIDE: begin
                if (r_op == mfq_pkg::OP_DISP) begin
                    n_state = (!r_have && r_lv != mfq_pkg::LVL_3) ?
                              mfq_pkg::SM_SCAN : mfq_pkg::SM_IDLE;
                end else begin
                    n_state = (r_have || r_lv == mfq_pkg::LVL_3) ?
                              mfq_pkg::SM_SCAN : mfq_pkg::SM_IDLE;
                end
            end
            default: n_state = mfq_pkg::SM_IDLE;
        endcase
    end

    // Datapath controls per state.
    always_comb begin
        n_op      = r_op;
        n_lv      = r_lv;
        n_idx     = r_idx;
        n_base    = r_base;
        n_cnt_arr = r_cnt_arr;
        n_have    = r_have;
        n_seen    = r_seen;
        n_b_idx   = r_b_idx;
        n_b_thr   = r_b_thr;
        n_b_pri   = r_b_pri;
        n_b_wait  = r_b_wait;
        n_b_burst = r_b_burst;
        n_b_arr   = r_b_arr;
        n_res     = '{status: mfq_pkg::STAT_NONE, thread: 16'd0,
                      level: mfq_pkg::LVL_NONE, prio: 8'd0};
        w_res_load = 1'b0;
        o_cmd_pop  = 1'b0;
        w_enq_wr   = 1'b0;
        w_disp_clr = 1'b0;
        w_age_wr   = 1'b0;
        case (r_state)
            mfq_pkg::SM_IDLE: begin
                if (i_cmd_valid && w_out_free) begin
                    o_cmd_pop = 1'b1;
                    n_op      = i_cmd.op;
                    n_idx     = '0;
                    n_have    = 1'b0;
                    n_seen    = '0;
                    n_base    = r_cnt_arr;
                    case (i_cmd.op)
                        mfq_pkg::OP_ENQ: begin
                            w_res_load = 1'b1;
                            n_res.status = mfq_pkg::STAT_ENQ;
                            if (i_cmd.level != mfq_pkg::LVL_NONE) begin
                                if (w_free_found) begin
                                    w_enq_wr    = 1'b1;
                                    n_cnt_arr   = r_cnt_arr + 16'd1;
                                    n_res.level = i_cmd.level;
                                end else begin
                                    n_res.status = mfq_pkg::STAT_FULL;
                                end
                            end
                        end
                        mfq_pkg::OP_DISP: n_lv = mfq_pkg::LVL_1;
                        mfq_pkg::OP_AGE:  n_lv = mfq_pkg::LVL_3;
                        default:          w_res_load = 1'b1;
                    endcase
                end
            end
            mfq_pkg::SM_SCAN: begin
                if (w_take) begin
                    n_have    = 1'b1;
                    n_b_idx   = r_idx;
                    n_b_thr   = r_thr[r_idx];
                    n_b_pri   = r_pri[r_idx];
                    n_b_wait  = r_wait[r_idx];
                    n_b_burst = r_burst[r_idx];
                    n_b_arr   = r_arr[r_idx];
                end
                n_idx = (r_idx == LAST_IDX) ? '0 : r_idx + IW'(1);
            end
            mfq_pkg::SM_DECIDE: begin
                n_have = 1'b0;
                n_idx  = '0;
                if (r_op == mfq_pkg::OP_DISP) begin
                    if (r_have) begin
                        w_disp_clr  = 1'b1;
                        w_res_load  = 1'b1;
                        n_res = '{status: mfq_pkg::STAT_DISP, thread: r_b_thr,
                                  level: r_lv, prio: r_b_pri};
                    end else if (r_lv != mfq_pkg::LVL_3) begin
                        n_lv = r_lv + 2'd1;
                    end else begin
                        w_res_load = 1'b1;
                    end
                end else begin
                    if (r_have) begin
                        w_age_wr = 1'b1;
                        n_seen[r_b_idx] = 1'b1;
                        if (w_age_lvl != r_lv) begin
                            n_cnt_arr = r_cnt_arr + 16'd1;
                        end
                    end else if (r_lv == mfq_pkg::LVL_3) begin
                        n_lv   = mfq_pkg::LVL_2;
                        n_seen = '0;
                        n_base = r_cnt_arr;
                    end else begin
                        w_res_load   = 1'b1;
                        n_res.status = mfq_pkg::STAT_AGED;
                    end
                end
            end
            default: ;
        endcase
    end

    // Control registers and the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mfq_pkg::SM_IDLE;
            r_cnt_arr   <= 16'd0;
            r_res_valid <= 1'b0;
            r_have      <= 1'b0;
            r_idx       <= '0;
            for (int i = 0; i < MAX_THREADS; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else begin
            r_state   <= n_state;
            r_cnt_arr <= n_cnt_arr;
            r_have    <= n_have;
            r_idx     <= n_idx;
            if (w_res_load) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
            if (w_enq_wr) begin
                r_valid[w_free_idx] <= 1'b1;
            end
            if (w_disp_clr) begin
                r_valid[r_b_idx] <= 1'b0;
            end
        end
        r_op      <= n_op;
        r_lv      <= n_lv;
        r_base    <= n_base;
        r_seen    <= n_seen;
        r_b_idx   <= n_b_idx;
        r_b_thr   <= n_b_thr;
        r_b_pri   <= n_b_pri;
        r_b_wait  <= n_b_wait;
        r_b_burst <= n_b_burst;
        r_b_arr   <= n_b_arr;
        if (w_res_load) begin
            r_res <= n_res;
        end
    end

    // Slot payload writes.
    always_ff @(posedge i_clk) begin
        if (w_enq_wr) begin
            r_thr[w_free_idx]   <= i_cmd.thread;
            r_pri[w_free_idx]   <= i_cmd.prio;
            r_wait[w_free_idx]  <= 17'd0;
            r_burst[w_free_idx] <= i_cmd.burst;
            r_lvl[w_free_idx]   <= i_cmd.level;
            r_arr[w_free_idx]   <= r_cnt_arr;
        end else if (w_age_wr) begin
            r_pri[r_b_idx]  <= w_age_pri;
            r_wait[r_b_idx] <= w_age_wait;
            r_lvl[r_b_idx]  <= w_age_lvl;
            r_arr[r_b_idx]  <= w_age_arr;
        end
    end

endmodule
`default_nettype wire

[design/three_level_feedback_queue_scheduler.sv]
// Three-level ready-thread scheduler with a table of MAX_THREADS slots. With
// the engine idle, an enqueue's result is loaded into the result register as
// the engine takes it from the queue. A dispatch scans the slot table one
// slot per cycle for each level it tries, from level 1 down to level 3.
// An aging tick picks one entry per scan of the table, for the entries in
// levels 3 and 2. A two-entry queue accepts new items while the engine
// works, and the result register holds a finished result until it is taken.
// Configuration must be written only while idle; the block itself does not
// enforce this.
`default_nettype none
module three_level_feedback_queue_scheduler #(
    parameter int MAX_THREADS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_op,
    input  wire logic [15:0] i_thread_id,
    input  wire logic [7:0]  i_priority_req,
    input  wire logic [19:0] i_remaining_burst,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [2:0]       o_status,
    output logic [15:0]      o_chosen_thread,
    output logic [1:0]       o_chosen_level,
    output logic [7:0]       o_chosen_priority
);

    mfq_pkg::t_cfg r_cfg;
    mfq_pkg::t_cmd w_cmd;
    mfq_pkg::t_res w_res;
    logic          w_cmd_valid, w_cmd_pop;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.thresh <= mfq_pkg::RST_THRESH;
            r_cfg.boost  <= mfq_pkg::RST_BOOST;
            r_cfg.inc    <= mfq_pkg::RST_INC;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mfq_pkg::REG_THRESH: r_cfg.thresh <= i_cfg_data;
                mfq_pkg::REG_BOOST:  r_cfg.boost  <= i_cfg_data[5:0];
                mfq_pkg::REG_INC:    r_cfg.inc    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    mfq_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_op              (i_op),
        .i_thread_id       (i_thread_id),
        .i_priority_req    (i_priority_req),
        .i_remaining_burst (i_remaining_burst),
        .o_cmd_valid       (w_cmd_valid),
        .o_cmd             (w_cmd),
        .i_cmd_pop         (w_cmd_pop)
    );

    mfq_back #(.MAX_THREADS(MAX_THREADS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .o_res_valid (o_out_valid),
        .i_res_ready (i_out_ready),
        .o_res       (w_res)
    );

    assign o_status          = w_res.status;
    assign o_chosen_thread   = w_res.thread;
    assign o_chosen_level    = w_res.level;
    assign o_chosen_priority = w_res.prio;

endmodule
`default_nettype wire

[design/mfq_checker.sv]
`default_nettype none
`include "assert_macros.svh"
module mfq_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [2:0]  o_status,
    input wire logic [15:0] o_chosen_thread,
    input wire logic [1:0]  o_chosen_level,
    input wire logic [7:0]  o_chosen_priority
);

    logic w_is_disp, w_no_ids, w_has_lvl, w_plain;

    // Decode the offered result once for the checks below.
    assign w_is_disp = (o_status == mfq_pkg::STAT_DISP);
    assign w_no_ids  = (o_chosen_thread == 16'd0) && (o_chosen_priority == 8'd0);
    assign w_has_lvl = (o_chosen_level != mfq_pkg::LVL_NONE);
    assign w_plain   = (o_status == mfq_pkg::STAT_NONE) || (o_status == mfq_pkg::STAT_FULL)
                       || (o_status == mfq_pkg::STAT_AGED);

    // A stalled result stays offered.
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)

    // Only a dispatch names a thread or a priority.
    `ASSERT_SAME(a_zero_fields, i_clk, i_rst_n, o_out_valid && !w_is_disp, w_no_ids)

    // A dispatched thread always comes from a real level.
    `ASSERT_SAME(a_disp_level, i_clk, i_rst_n, o_out_valid && w_is_disp, w_has_lvl)

    // Empty, full and aging results carry no level.
    `ASSERT_SAME(a_no_level, i_clk, i_rst_n, o_out_valid && w_plain, !w_has_lvl)

endmodule

bind three_level_feedback_queue_scheduler mfq_checker u_mfq_checker (.*);
`default_nettype wire
